/* hw/rtl/tqla_pkg.sv */
// Shared types, constants and helpers for the tabular Q-learning agent.
// Used by every module under hw/rtl; depends on nothing else.
package tqla_pkg;

  localparam int DEF_NUM_STATES  = 16;
  localparam int DEF_NUM_ACTIONS = 4;

  localparam int Q_W       = 32;  // Q16.16 table entry
  localparam int FRAC_W    = 17;  // Q1.16 fraction, 65536 is one
  localparam int FRAC_BITS = 16;
  localparam int MUL_X_W   = 34;  // multiplier signed operand
  localparam int MUL_P_W   = 35;  // rounded product
  localparam int ACC_W     = 36;  // update sum before clipping
  localparam int DRAW_W    = 16;  // random and tie draws
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(65536);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEARN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIONS  = 2'd3;

  localparam logic [6:0]        EPSILON_RST  = 7'd10;
  localparam logic [FRAC_W-1:0] LEARN_RST    = FRAC_W'(32768);
  localparam logic [FRAC_W-1:0] DISCOUNT_RST = FRAC_W'(58982);
  localparam logic [2:0]        ACTIONS_RST  = 3'd2;

  // operation codes
  localparam logic OP_SELECT = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [3:0]        state_index;
    logic [1:0]        action_index;
    logic signed [31:0] reward;
    logic [3:0]        next_state;
    logic [6:0]        explore_draw;
    logic [15:0]       random_draw;
    logic [15:0]       tie_draw;
  } item_t;

  typedef struct packed {
    logic [1:0]         chosen_action;
    logic               explored;
    logic signed [31:0] q_value;
    logic               saturated;
  } result_t;

  // v mod m for a 4-bit v by repeated subtraction (m >= 2, so eight steps suffice)
  function automatic logic [3:0] mod_small(input logic [3:0] v, input int m);
    logic [3:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (int'(r) >= m) r = r - 4'(m);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/tqla_remu.sv */
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on tqla_pkg for the draw width.
module tqla_remu import tqla_pkg::*; #(
  parameter int DIV_W = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DRAW_W-1:0]  dividend,
  input  logic [DIV_W-1:0]   divisor,
  output logic               done,
  output logic [DIV_W-1:0]   rem
);

  localparam int STEP_W = $clog2(DRAW_W);

  logic              active;
  logic [STEP_W-1:0] step;
  logic [DRAW_W-1:0] shreg;
  logic [DIV_W-1:0]  div;
  logic [DIV_W:0]    trial;

  // remainder stays below the divisor, so the shifted value is below twice it
  assign trial = {rem, shreg[DRAW_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
        shreg  <= dividend;
        div    <= divisor;
        rem    <= '0;
      end else if (active) begin
        if (trial >= {1'b0, div}) begin
          rem <= DIV_W'(trial - {1'b0, div});
        end else begin
          rem <= trial[DIV_W-1:0];
        end
        shreg <= shreg << 1;
        step  <= step + 1'b1;
        if (step == STEP_W'(DRAW_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/tqla_mul.sv */
// Shared fraction multiplier: registered round(frac * x / 65536), round half up.
// Depends on tqla_pkg for operand widths.
module tqla_mul import tqla_pkg::*; (
  input  logic                      clk,
  input  logic [FRAC_W-1:0]         frac,
  input  logic signed [MUL_X_W-1:0] x,
  output logic signed [MUL_P_W-1:0] p
);

  localparam int PROD_W = FRAC_W + MUL_X_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;

  assign prod     = $signed({1'b0, frac}) * x;
  assign prod_rnd = prod + PROD_W'(32768);

  always_ff @(posedge clk) begin
    p <= prod_rnd[MUL_P_W+FRAC_BITS-1:FRAC_BITS];
  end

endmodule

/* hw/rtl/tabular_q_learning_agent.sv */
// Channel   Signals                          Moves
// item      item_valid/item_ready, item      one select or update request
// result    result_valid/result_ready, result one result per request
// cfg       cfg_write, cfg_index, cfg_data   register writes, no wait
//
// Update, n = actions in use: the row scan reads the n entries of the row from the Q table
// memory one entry per cycle, then the shared multiplier runs twice.
// Select: the same row scan, then the bit-serial remainder unit divides the 16-bit draw;
// when exploring its remainder is the action, else the tie pick walks the tie mask one action per cycle.
// After reset all NUM_STATES * 2**clog2(NUM_ACTIONS) table entries are cleared one entry
// a cycle, with item_ready low. A stalled result stays in the output register
// and the next item is taken meanwhile.
// Depends on tqla_pkg, tqla_remu, tqla_mul.
module tabular_q_learning_agent import tqla_pkg::*; #(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_ACTIONS = DEF_NUM_ACTIONS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int ST_W   = $clog2(NUM_STATES);
  localparam int ACT_W  = $clog2(NUM_ACTIONS);
  localparam int CNT_W  = $clog2(NUM_ACTIONS + 1);
  localparam int ADDR_W = ST_W + ACT_W;
  localparam int DEPTH  = NUM_STATES << ACT_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DIV, S_DIVW, S_PICK,
    S_RDQ, S_MULG, S_TGT, S_MULA, S_WB, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [6:0]        epsilon;
  logic [FRAC_W-1:0] learn_rate;
  logic [FRAC_W-1:0] discount;
  logic [2:0]        actions_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon        <= EPSILON_RST;
      learn_rate     <= LEARN_RST;
      discount       <= DISCOUNT_RST;
      actions_in_use <= ACTIONS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_EPSILON:  epsilon        <= cfg_data[6:0];
        REG_LEARN:    learn_rate     <= cfg_data;
        REG_DISCOUNT: discount       <= cfg_data;
        REG_ACTIONS:  actions_in_use <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0]  n_used;
  logic [FRAC_W-1:0] alpha;
  logic [FRAC_W-1:0] gamma;

  always_comb begin
    if (actions_in_use == 3'd0) begin
      n_used = CNT_W'(1);
    end else if (int'(actions_in_use) > NUM_ACTIONS) begin
      n_used = CNT_W'(NUM_ACTIONS);
    end else begin
      n_used = CNT_W'(actions_in_use);
    end
  end

  assign alpha = (learn_rate > ONE_Q16) ? ONE_Q16 : learn_rate;
  assign gamma = (discount > ONE_Q16) ? ONE_Q16 : discount;

  // Q table
  logic signed [Q_W-1:0] qmem [DEPTH];
  logic signed [Q_W-1:0] rd_data;
  logic [ADDR_W-1:0]     raddr;
  logic [ADDR_W-1:0]     waddr;
  logic signed [Q_W-1:0] wdata;
  logic                  we;

  // item registers
  logic                  op_q;
  logic [ST_W-1:0]       s_q;
  logic [ACT_W-1:0]      a_q;
  logic [1:0]            a_raw_q;
  logic signed [31:0]    reward_q;
  logic [ST_W-1:0]       scan_row;
  logic                  explore_q;
  logic [DRAW_W-1:0]     draw_q;

  // scan
  logic [CNT_W-1:0]       issue_idx;
  logic                   issue;
  logic                   rd_vld;
  logic [ACT_W-1:0]       rd_idx;
  logic signed [Q_W-1:0]  best;
  logic [CNT_W-1:0]       tie_cnt;
  logic [NUM_ACTIONS-1:0] tie_mask;
  logic [NUM_ACTIONS-1:0] rd_onehot;

  // pick and update
  logic [CNT_W-1:0]           pick_k;
  logic [ACT_W-1:0]           pick_idx;
  logic signed [Q_W-1:0]      q_reg;
  logic signed [MUL_X_W-1:0]  diff;
  logic signed [ACC_W-1:0]    diff_full;
  logic signed [ACC_W-1:0]    nv_full;
  logic signed [Q_W-1:0]      nv_sat;
  logic                       nv_clip;
  logic [ADDR_W-1:0]          clr_addr;
  result_t                    res;

  // shared units
  logic                      div_start;
  logic                      div_done;
  logic [CNT_W-1:0]          div_rem;
  logic [FRAC_W-1:0]         mul_frac;
  logic signed [MUL_X_W-1:0] mul_x;
  logic signed [MUL_P_W-1:0] mul_p;

  tqla_remu #(.DIV_W(CNT_W)) u_remu (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (draw_q),
    .divisor  (explore_q ? n_used : tie_cnt),
    .done     (div_done),
    .rem      (div_rem)
  );

  tqla_mul u_mul (
    .clk  (clk),
    .frac (mul_frac),
    .x    (mul_x),
    .p    (mul_p)
  );

  assign div_start = (state == S_DIV);
  assign mul_frac  = (state == S_MULG) ? gamma : alpha;
  assign mul_x     = (state == S_MULG) ? MUL_X_W'(best) : diff;

  assign item_ready = (state == S_IDLE);
  assign issue      = (state == S_SCAN) && (issue_idx < n_used);
  assign rd_onehot  = NUM_ACTIONS'(1) << rd_idx;

  assign raddr = (state == S_SCAN) ? {scan_row, issue_idx[ACT_W-1:0]} : {s_q, a_q};
  assign we    = (state == S_CLEAR) || (state == S_WB);
  assign waddr = (state == S_CLEAR) ? clr_addr : {s_q, a_q};
  assign wdata = (state == S_CLEAR) ? '0 : nv_sat;

  always_ff @(posedge clk) begin
    if (we) qmem[waddr] <= wdata;
    rd_data <= qmem[raddr];
  end

  // target minus old value, then new value = old + round(alpha * that)
  assign diff_full = ACC_W'(reward_q) + ACC_W'(mul_p) - ACC_W'(q_reg);
  assign nv_full   = ACC_W'(q_reg) + ACC_W'(mul_p);

  always_comb begin
    nv_clip = 1'b1;
    if (nv_full > ACC_W'(64'sd2147483647)) begin
      nv_sat = 32'sh7fffffff;
    end else if (nv_full < ACC_W'(-64'sd2147483648)) begin
      nv_sat = 32'sh80000000;
    end else begin
      nv_sat  = nv_full[Q_W-1:0];
      nv_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      issue_idx    <= '0;
      rd_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_vld <= issue;
      // S_DONE reloads the output register itself
      if (result_valid && result_ready && state != S_DONE) result_valid <= 1'b0;

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (item_valid) begin
            op_q      <= item.operation;
            s_q       <= ST_W'(mod_small(item.state_index, NUM_STATES));
            a_q       <= ACT_W'(mod_small({2'b00, item.action_index}, NUM_ACTIONS));
            a_raw_q   <= item.action_index;
            reward_q  <= item.reward;
            explore_q <= (item.explore_draw < epsilon);
            draw_q    <= (item.explore_draw < epsilon) ? item.random_draw : item.tie_draw;
            scan_row  <= (item.operation == OP_UPDATE)
                         ? ST_W'(mod_small(item.next_state, NUM_STATES))
                         : ST_W'(mod_small(item.state_index, NUM_STATES));
            issue_idx <= '0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) issue_idx <= issue_idx + 1'b1;
          rd_idx <= issue_idx[ACT_W-1:0];
          if (rd_vld) begin
            if (rd_idx == '0 || rd_data > best) begin
              best     <= rd_data;
              tie_cnt  <= CNT_W'(1);
              tie_mask <= rd_onehot;
            end else if (rd_data == best) begin
              tie_cnt  <= tie_cnt + 1'b1;
              tie_mask <= tie_mask | rd_onehot;
            end
          end
          if (!issue && !rd_vld) begin
            state <= (op_q == OP_UPDATE) ? S_RDQ : S_DIV;
          end
        end
        S_DIV: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            res.explored  <= explore_q;
            res.q_value   <= best;
            res.saturated <= 1'b0;
            if (explore_q) begin
              res.chosen_action <= 2'(div_rem);
              state             <= S_DONE;
            end else begin
              pick_k   <= div_rem;
              pick_idx <= '0;
              state    <= S_PICK;
            end
          end
        end
        S_PICK: begin
          // walk to the k-th tied action
          if (tie_mask[pick_idx]) begin
            if (pick_k == '0) begin
              res.chosen_action <= 2'(pick_idx);
              state             <= S_DONE;
            end else begin
              pick_k <= pick_k - 1'b1;
            end
          end
          pick_idx <= pick_idx + 1'b1;
        end
        S_RDQ: begin
          state <= S_MULG;
        end
        S_MULG: begin
          q_reg <= rd_data;
          state <= S_TGT;
        end
        S_TGT: begin
          diff  <= diff_full[MUL_X_W-1:0];
          state <= S_MULA;
        end
        S_MULA: begin
          state <= S_WB;
        end
        S_WB: begin
          res.chosen_action <= a_raw_q;
          res.explored      <= 1'b0;
          res.q_value       <= nv_sat;
          res.saturated     <= nv_clip;
          state             <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result       <= res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
